>>> src/assert_macros.svh
// Assertion macros for the RTL decoder core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> src/kscd_pkg.sv
// Types, codes and translation tables of the scan code decoder.
package kscd_pkg;

    localparam int unsigned TABLE_SIZE = 59;

    localparam int unsigned CODE_W   = 8;
    localparam int unsigned ACTION_W = 4;
    localparam int unsigned CHAR_W   = 7;
    localparam int unsigned TERM_W   = 2;
    localparam int unsigned ATTR_W   = 8;
    localparam int unsigned IDX_W    = 6;
    localparam int unsigned RES_W    = ACTION_W + CHAR_W + TERM_W + ATTR_W;
    localparam int unsigned M_DATA_W = 24;
    localparam int unsigned S_DATA_W = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE      = 4'd0,
        ACT_CHAR      = 4'd1,
        ACT_ENTER     = 4'd2,
        ACT_BACKSPACE = 4'd3,
        ACT_TAB       = 4'd4,
        ACT_TERM      = 4'd5,
        ACT_PREV      = 4'd6,
        ACT_NEXT      = 4'd7,
        ACT_CLEAR     = 4'd8,
        ACT_COLOUR    = 4'd9,
        ACT_CLASSIC   = 4'd10
    } t_action;

    typedef struct packed {
        logic [ATTR_W-1:0] attribute;
        logic [TERM_W-1:0] terminal;
        logic [CHAR_W-1:0] character;
        t_action           action;
    } t_result;

    // Scan codes
    localparam logic [CODE_W-1:0] SC_LSHIFT     = 8'h2A;
    localparam logic [CODE_W-1:0] SC_RSHIFT     = 8'h36;
    localparam logic [CODE_W-1:0] SC_LSHIFT_REL = 8'hAA;
    localparam logic [CODE_W-1:0] SC_RSHIFT_REL = 8'hB6;
    localparam logic [CODE_W-1:0] SC_CAPS       = 8'h3A;
    localparam logic [CODE_W-1:0] SC_CAPS_REL   = 8'hBA;
    localparam logic [CODE_W-1:0] SC_CTRL       = 8'h1D;
    localparam logic [CODE_W-1:0] SC_CTRL_REL   = 8'h9D;
    localparam logic [CODE_W-1:0] SC_ALT        = 8'h38;
    localparam logic [CODE_W-1:0] SC_ALT_REL    = 8'hB8;
    localparam logic [CODE_W-1:0] SC_F1         = 8'h3B;
    localparam logic [CODE_W-1:0] SC_F3         = 8'h3D;
    localparam logic [CODE_W-1:0] SC_UP         = 8'h48;
    localparam logic [CODE_W-1:0] SC_DOWN       = 8'h50;

    // ASCII
    localparam logic [CHAR_W-1:0] CH_NUL = 7'h00;
    localparam logic [CHAR_W-1:0] CH_BS  = 7'h08;
    localparam logic [CHAR_W-1:0] CH_TAB = 7'h09;
    localparam logic [CHAR_W-1:0] CH_LF  = 7'h0A;
    localparam logic [CHAR_W-1:0] CH_L   = 7'h6C;
    localparam logic [CHAR_W-1:0] CH_R   = 7'h72;
    localparam logic [CHAR_W-1:0] CH_G   = 7'h67;
    localparam logic [CHAR_W-1:0] CH_B   = 7'h62;
    localparam logic [CHAR_W-1:0] CH_W   = 7'h77;
    localparam logic [CHAR_W-1:0] CH_D   = 7'h64;
    localparam logic [CHAR_W-1:0] CH_Q   = 7'h71;
    localparam logic [CHAR_W-1:0] CH_UC_A = 7'h41;
    localparam logic [CHAR_W-1:0] CH_UC_Z = 7'h5A;
    localparam logic [CHAR_W-1:0] CASE_OFS = 7'h20;

    // Attributes
    localparam logic [ATTR_W-1:0] ATTR_RED     = 8'h4E;
    localparam logic [ATTR_W-1:0] ATTR_GREEN   = 8'h2E;
    localparam logic [ATTR_W-1:0] ATTR_BLUE    = 8'h1E;
    localparam logic [ATTR_W-1:0] ATTR_WHITE   = 8'hF1;
    localparam logic [ATTR_W-1:0] ATTR_DEFAULT = 8'h0F;
    localparam logic [ATTR_W-1:0] ATTR_CLASSIC = 8'h02;

    localparam logic [CHAR_W-1:0] LOWER_TAB [TABLE_SIZE] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00, 7'h00, 7'h20, 7'h00
    };

    localparam logic [CHAR_W-1:0] UPPER_TAB [TABLE_SIZE] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
        7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00, 7'h00, 7'h20, 7'h00
    };

    function automatic logic is_letter(input logic [CODE_W-1:0] code);
        return (code >= 8'd16 && code <= 8'd25) || (code >= 8'd30 && code <= 8'd38) ||
               (code >= 8'd44 && code <= 8'd50);
    endfunction

endpackage

>>> src/keyboard_scan_code_decoder_core.sv
// Set-1 scan code decoder: modifier tracking, table lookup and action output.
// The input register and then the result register lie between input accept and result valid.
// Throughput: one item per cycle unless stalled; lookup and modifier update are combinational.
// A stalled output holds the result; the input register still takes an item while it is free.
// Reset (synchronous, active low) clears valid flags and the shift, caps, ctrl and alt flags.
`include "assert_macros.svh"

module keyboard_scan_code_decoder_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [kscd_pkg::S_DATA_W-1:0]   i_s_tdata,  // [7:0] scan_code
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [3:0] action, [10:4] character, [12:11] terminal, [20:13] attribute, [23:21] zero
    output logic [kscd_pkg::M_DATA_W-1:0]   o_m_tdata
);
    import kscd_pkg::*;

    logic                  r_in_valid;
    logic [CODE_W-1:0]     r_code;
    logic                  r_out_valid;
    t_result               r_result;
    logic                  r_shift;
    logic                  r_caps;
    logic                  r_ctrl;
    logic                  r_alt;

    logic                  n_shift;
    logic                  n_caps;
    logic                  n_ctrl;
    logic                  n_alt;
    t_result               n_result;

    logic                  advance;
    logic [IDX_W-1:0]      idx;
    logic [CHAR_W-1:0]     lo_ch;
    logic [CHAR_W-1:0]     up_ch;
    logic                  use_upper;
    logic [CHAR_W-1:0]     ch;
    logic [CHAR_W-1:0]     lc;

    assign advance    = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || advance;

    assign idx   = r_code[IDX_W-1:0];
    assign lo_ch = (r_code < CODE_W'(TABLE_SIZE)) ? LOWER_TAB[idx] : CH_NUL;
    assign up_ch = (r_code < CODE_W'(TABLE_SIZE)) ? UPPER_TAB[idx] : CH_NUL;
    assign use_upper = is_letter(r_code) ? (r_shift ^ r_caps) : r_shift;
    assign ch = use_upper ? up_ch : lo_ch;
    assign lc = (ch >= CH_UC_A && ch <= CH_UC_Z) ? (ch + CASE_OFS) : ch;

    always_comb begin
        n_shift  = r_shift;
        n_caps   = r_caps;
        n_ctrl   = r_ctrl;
        n_alt    = r_alt;
        n_result = '0;
        n_result.action = ACT_NONE;
        priority if (r_code == SC_LSHIFT || r_code == SC_RSHIFT) begin
            n_shift = 1'b1;
        end else if (r_code == SC_LSHIFT_REL || r_code == SC_RSHIFT_REL) begin
            n_shift = 1'b0;
        end else if (r_code == SC_CAPS) begin
            n_caps = !r_caps;
        end else if (r_code == SC_CTRL) begin
            n_ctrl = 1'b1;
        end else if (r_code == SC_CTRL_REL) begin
            n_ctrl = 1'b0;
        end else if (r_code == SC_ALT) begin
            n_alt = 1'b1;
        end else if (r_code == SC_ALT_REL) begin
            n_alt = 1'b0;
        end else if (r_code == SC_CAPS_REL) begin
            n_result.action = ACT_NONE;
        end else if (r_alt && r_code >= SC_F1 && r_code <= SC_F3) begin
            n_result.action   = ACT_TERM;
            n_result.terminal = TERM_W'(r_code - SC_F1);
        end else if (r_code == SC_UP) begin
            n_result.action = ACT_PREV;
        end else if (r_code == SC_DOWN) begin
            n_result.action = ACT_NEXT;
        end else if (lo_ch == CH_NUL) begin
            n_result.action = ACT_NONE;
        end else if (ch == CH_LF) begin
            n_result.action = ACT_ENTER;
        end else if (ch == CH_BS) begin
            n_result.action = ACT_BACKSPACE;
        end else if (ch == CH_TAB) begin
            n_result.action = ACT_TAB;
        end else if (r_ctrl && lc == CH_L) begin
            n_result.action = ACT_CLEAR;
        end else if (r_ctrl && lc == CH_R) begin
            n_result.action    = ACT_COLOUR;
            n_result.attribute = ATTR_RED;
        end else if (r_ctrl && lc == CH_G) begin
            n_result.action    = ACT_COLOUR;
            n_result.attribute = ATTR_GREEN;
        end else if (r_ctrl && lc == CH_B) begin
            n_result.action    = ACT_COLOUR;
            n_result.attribute = ATTR_BLUE;
        end else if (r_ctrl && lc == CH_W) begin
            n_result.action    = ACT_COLOUR;
            n_result.attribute = ATTR_WHITE;
        end else if (r_ctrl && lc == CH_D) begin
            n_result.action    = ACT_COLOUR;
            n_result.attribute = ATTR_DEFAULT;
        end else if (r_ctrl && lc == CH_Q) begin
            n_result.action    = ACT_CLASSIC;
            n_result.attribute = ATTR_CLASSIC;
        end else begin
            n_result.action    = ACT_CHAR;
            n_result.character = ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_shift     <= 1'b0;
            r_caps      <= 1'b0;
            r_ctrl      <= 1'b0;
            r_alt       <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (advance && r_in_valid) begin
                r_shift <= n_shift;
                r_caps  <= n_caps;
                r_ctrl  <= n_ctrl;
                r_alt   <= n_alt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_code <= i_s_tdata;
        end
        if (advance && r_in_valid) begin
            r_result <= n_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(M_DATA_W - RES_W)'(0), r_result};

    `ASSERT_IMPL(a_char_only_fields, i_clk, i_rst_n,
        r_out_valid && r_result.action == ACT_CHAR,
        r_result.terminal == '0 && r_result.attribute == '0,
        "char result carries terminal or attribute")
    `ASSERT_IMPL(a_non_char_no_char, i_clk, i_rst_n,
        r_out_valid && r_result.action != ACT_CHAR,
        r_result.character == '0,
        "non-char result carries a character")
    `ASSERT_IMPL(a_term_range, i_clk, i_rst_n,
        r_out_valid && r_result.action == ACT_TERM,
        r_result.terminal != 2'd3,
        "terminal index out of range")
    `ASSERT_NEXT(a_caps_toggle, i_clk, i_rst_n,
        advance && r_in_valid && r_code == SC_CAPS,
        r_caps != $past(r_caps),
        "caps lock did not toggle")
    `ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n,
        !o_s_tready,
        r_in_valid && r_out_valid && !i_m_tready,
        "input stalled without a full pipeline")

endmodule
